FILE: rtl/core/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// Shared widths, codes and types of the stick input conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package sic_pkg;

  // field widths
  localparam int RAW_W      = 12;
  localparam int KEY_W      = 4;
  localparam int VAL_W      = 10;
  localparam int STEP_W     = 7;
  localparam int CENTER_W   = 10;
  localparam int TRIM_W     = 11;
  localparam int OFF_W      = 11;
  localparam int SUM_W      = 15;
  localparam int CAL_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int NUM_LANES  = 4;

  // value limits
  localparam int OUT_MAX    = 1000;
  localparam int TRIM_LIMIT = 1000;

  // reciprocal precision of the offset average
  localparam int DIV_SHIFT  = 20;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CAL_SAMPLES_DEF = 10;

  // register reset values
  localparam logic [STEP_W-1:0]   TRIM_STEP_RST    = STEP_W'(10);
  localparam logic [CENTER_W-1:0] STICK_CENTER_RST = CENTER_W'(500);

  // lane order
  localparam int LANE_YAW      = 0;
  localparam int LANE_THROTTLE = 1;
  localparam int LANE_PITCH    = 2;
  localparam int LANE_ROLL     = 3;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE     = 4'd0,
    KEY_STOP     = 4'd1,
    KEY_HOLD     = 4'd2,
    KEY_CAL      = 4'd3,
    KEY_UNLOCK   = 4'd4,
    KEY_ROLL_DN  = 4'd5,
    KEY_ROLL_UP  = 4'd6,
    KEY_PITCH_DN = 4'd7,
    KEY_PITCH_UP = 4'd8
  } key_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TRIM_STEP    = 2'd0,
    CFG_STICK_CENTER = 2'd1
  } cfg_idx_t;

  // per-beat control from the key logic to every lane
  typedef struct packed {
    logic clear;   // calibration start: offsets and sums cleared
    logic sample;  // this beat is a calibration sample
    logic last;    // last calibration sample, offsets written
  } lane_ctl_t;

  typedef struct packed {
    logic stop;
    logic hold;
    logic unlock;
    logic calibrating;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sic_in_if.sv
// ----------------------------------------------------------------------------
// sic_in_if
// Raw stick sample channel: four converter samples and a key code.
// ----------------------------------------------------------------------------
`default_nettype none

interface sic_in_if;
  logic                         valid;
  logic                         ready;
  logic [sic_pkg::RAW_W-1:0]    raw_yaw;
  logic [sic_pkg::RAW_W-1:0]    raw_throttle;
  logic [sic_pkg::RAW_W-1:0]    raw_pitch;
  logic [sic_pkg::RAW_W-1:0]    raw_roll;
  logic [sic_pkg::KEY_W-1:0]    key_code;

  modport source (
    output valid, raw_yaw, raw_throttle, raw_pitch, raw_roll, key_code,
    input  ready
  );
  modport sink (
    input  valid, raw_yaw, raw_throttle, raw_pitch, raw_roll, key_code,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/sic_out_if.sv
// ----------------------------------------------------------------------------
// sic_out_if
// Conditioned stick channel: four control values and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface sic_out_if;
  logic                         valid;
  logic                         ready;
  logic [sic_pkg::VAL_W-1:0]    yaw_out;
  logic [sic_pkg::VAL_W-1:0]    throttle_out;
  logic [sic_pkg::VAL_W-1:0]    pitch_out;
  logic [sic_pkg::VAL_W-1:0]    roll_out;
  logic                         stop_flag;
  logic                         hold_height_flag;
  logic                         unlock_flag;
  logic                         calibrating;

  modport source (
    output valid, yaw_out, throttle_out, pitch_out, roll_out,
           stop_flag, hold_height_flag, unlock_flag, calibrating,
    input  ready
  );
  modport sink (
    input  valid, yaw_out, throttle_out, pitch_out, roll_out,
           stop_flag, hold_height_flag, unlock_flag, calibrating,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/sic_cfg_if.sv
// ----------------------------------------------------------------------------
// sic_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sic_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sic_pkg::CFG_ADDR_W-1:0]  addr;
  logic [sic_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sic_lane.sv
// ----------------------------------------------------------------------------
// sic_lane
// One stick channel: scaling stage, calibration sum and offset, trim and
// clamp of the conditioned value.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_lane #(
  parameter int SAMPLE_BITS = sic_pkg::SAMPLE_BITS_DEF,
  parameter int CAL_SAMPLES = sic_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                load,
  input  wire logic                                fire,
  input  wire logic [sic_pkg::RAW_W-1:0]           raw,
  input  wire sic_pkg::lane_ctl_t                  ctl,
  input  wire logic signed [sic_pkg::TRIM_W-1:0]   trim,
  input  wire logic [sic_pkg::CENTER_W-1:0]        center,
  output logic [sic_pkg::VAL_W-1:0]                value
);

  // x*1000/full via reciprocal, exact for x <= full with a 2*SB shift
  localparam longint unsigned FULL      = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam int              SCL_SHIFT = 2 * SAMPLE_BITS;
  localparam int              MUL_W     = SAMPLE_BITS + 11;
  localparam longint unsigned SCL_MUL   =
    ((64'd1000 << SCL_SHIFT) + FULL - 64'd1) / FULL;
  localparam int              PROD_W    = SAMPLE_BITS + MUL_W;

  localparam int              RECIP_W   = sic_pkg::DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(
    ((64'd1 << sic_pkg::DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam int              DPROD_W   = sic_pkg::SUM_W + RECIP_W;

  localparam int              V_W       = 13;

  logic [SAMPLE_BITS-1:0]               x;
  logic [PROD_W-1:0]                    scl_prod;
  logic [sic_pkg::VAL_W-1:0]            scaled_r;

  logic signed [sic_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic signed [sic_pkg::OFF_W-1:0]     offset_r, offset_nxt;
  logic signed [sic_pkg::OFF_W-1:0]     offset_eff;
  logic signed [sic_pkg::SUM_W-1:0]     delta;
  logic signed [sic_pkg::SUM_W-1:0]     sum_add;
  logic [sic_pkg::SUM_W-1:0]            mag;
  logic [DPROD_W-1:0]                   div_prod;
  logic [sic_pkg::OFF_W-1:0]            quot;
  logic signed [V_W-1:0]                v;

  // stage a: scaling
  assign x        = SAMPLE_BITS'(raw);
  assign scl_prod = PROD_W'(x) * PROD_W'(MUL_W'(SCL_MUL));

  always_ff @(posedge clk) begin
    if (load) begin
      scaled_r <= scl_prod[SCL_SHIFT +: sic_pkg::VAL_W];
    end
  end

  // stage b: value and calibration
  assign offset_eff = ctl.clear ? '0 : offset_r;
  assign delta      = sic_pkg::SUM_W'($signed({1'b0, scaled_r}))
                    - sic_pkg::SUM_W'($signed({1'b0, center}));
  assign sum_add    = sum_r + delta;
  assign mag        = sum_add[sic_pkg::SUM_W-1] ? sic_pkg::SUM_W'(-sum_add)
                                                : sic_pkg::SUM_W'(sum_add);
  assign div_prod   = DPROD_W'(mag) * DPROD_W'(RECIP);
  assign quot       = div_prod[sic_pkg::DIV_SHIFT +: sic_pkg::OFF_W];

  always_comb begin
    sum_nxt    = sum_r;
    offset_nxt = offset_r;
    if (ctl.clear) begin
      sum_nxt    = '0;
      offset_nxt = '0;
    end else if (ctl.sample) begin
      sum_nxt = sum_add;
      if (ctl.last) begin
        offset_nxt = sum_add[sic_pkg::SUM_W-1] ? $signed(-quot) : $signed(quot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      offset_r <= '0;
    end else if (fire) begin
      sum_r    <= sum_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign v = V_W'($signed({1'b0, scaled_r})) - V_W'(offset_eff) + V_W'(trim);

  always_comb begin
    if (v >= V_W'(sic_pkg::OUT_MAX)) begin
      value = sic_pkg::VAL_W'(sic_pkg::OUT_MAX);
    end else if (v <= 0) begin
      value = '0;
    end else begin
      value = v[sic_pkg::VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sic_ctrl.sv
// ----------------------------------------------------------------------------
// sic_ctrl
// Key edge logic: sticky request flags, pitch and roll trims and the
// calibration sample counter.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_ctrl #(
  parameter int CAL_SAMPLES = sic_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                fire,
  input  wire logic [sic_pkg::KEY_W-1:0]           key,
  input  wire logic [sic_pkg::STEP_W-1:0]          trim_step,
  output sic_pkg::lane_ctl_t                       ctl,
  output logic signed [sic_pkg::TRIM_W-1:0]        pitch_trim,
  output logic signed [sic_pkg::TRIM_W-1:0]        roll_trim,
  output sic_pkg::status_t                         status
);

  localparam logic [sic_pkg::CAL_W-1:0] CAL_LOAD = sic_pkg::CAL_W'(CAL_SAMPLES);

  logic [sic_pkg::KEY_W-1:0]            prev_key_r;
  logic [sic_pkg::CAL_W-1:0]            cal_r, cal_nxt;
  logic signed [sic_pkg::TRIM_W-1:0]    pitch_trim_r, pitch_trim_nxt;
  logic signed [sic_pkg::TRIM_W-1:0]    roll_trim_r, roll_trim_nxt;
  logic [2:0]                           flags_r, flags_nxt;
  logic                                 key_edge;
  logic                                 cal_start;

  function automatic logic signed [sic_pkg::TRIM_W-1:0] trim_add(
    input logic signed [sic_pkg::TRIM_W-1:0] t,
    input logic [sic_pkg::STEP_W-1:0]        step,
    input logic                              down
  );
    logic signed [sic_pkg::TRIM_W:0] d;
    logic signed [sic_pkg::TRIM_W:0] s;
    d = $signed({{(sic_pkg::TRIM_W + 1 - sic_pkg::STEP_W){1'b0}}, step});
    if (down) begin
      d = -d;
    end
    s = (sic_pkg::TRIM_W + 1)'(t) + d;
    if (s > (sic_pkg::TRIM_W + 1)'(sic_pkg::TRIM_LIMIT)) begin
      s = (sic_pkg::TRIM_W + 1)'(sic_pkg::TRIM_LIMIT);
    end else if (s < -(sic_pkg::TRIM_W + 1)'(sic_pkg::TRIM_LIMIT)) begin
      s = -(sic_pkg::TRIM_W + 1)'(sic_pkg::TRIM_LIMIT);
    end
    return s[sic_pkg::TRIM_W-1:0];
  endfunction

  // keys only count while no calibration is gathering
  assign key_edge  = (cal_r == '0) && (key != prev_key_r);
  assign cal_start = key_edge && (sic_pkg::key_t'(key) == sic_pkg::KEY_CAL);

  always_comb begin
    cal_nxt        = cal_r;
    pitch_trim_nxt = pitch_trim_r;
    roll_trim_nxt  = roll_trim_r;
    flags_nxt      = flags_r;
    if (cal_r != '0) begin
      cal_nxt = cal_r - 1'b1;
    end else if (key_edge) begin
      case (sic_pkg::key_t'(key))
        sic_pkg::KEY_STOP:     flags_nxt[0] = 1'b1;
        sic_pkg::KEY_HOLD:     flags_nxt[1] = 1'b1;
        sic_pkg::KEY_UNLOCK:   flags_nxt[2] = 1'b1;
        sic_pkg::KEY_CAL: begin
          pitch_trim_nxt = '0;
          roll_trim_nxt  = '0;
          cal_nxt        = CAL_LOAD;
        end
        sic_pkg::KEY_ROLL_DN:  roll_trim_nxt  = trim_add(roll_trim_r, trim_step, 1'b1);
        sic_pkg::KEY_ROLL_UP:  roll_trim_nxt  = trim_add(roll_trim_r, trim_step, 1'b0);
        sic_pkg::KEY_PITCH_DN: pitch_trim_nxt = trim_add(pitch_trim_r, trim_step, 1'b1);
        sic_pkg::KEY_PITCH_UP: pitch_trim_nxt = trim_add(pitch_trim_r, trim_step, 1'b0);
        default: ;
      endcase
    end
  end

  // the beat sees the trims and flags after its own key
  always_comb begin
    ctl.clear          = cal_start;
    ctl.sample         = (cal_r != '0);
    ctl.last           = (cal_r == sic_pkg::CAL_W'(1));
    pitch_trim         = pitch_trim_nxt;
    roll_trim          = roll_trim_nxt;
    status.stop        = flags_nxt[0];
    status.hold        = flags_nxt[1];
    status.unlock      = flags_nxt[2];
    status.calibrating = (cal_r != '0) || cal_start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r   <= '0;
      cal_r        <= '0;
      pitch_trim_r <= '0;
      roll_trim_r  <= '0;
      flags_r      <= '0;
    end else if (fire) begin
      prev_key_r   <= key;
      cal_r        <= cal_nxt;
      pitch_trim_r <= pitch_trim_nxt;
      roll_trim_r  <= roll_trim_nxt;
      flags_r      <= flags_nxt;
    end
  end

  a_cal_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r <= CAL_LOAD)
    else $error("calibration counter above sample count");

  a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
    pitch_trim_r <= sic_pkg::TRIM_W'(sic_pkg::TRIM_LIMIT)
    && pitch_trim_r >= -sic_pkg::TRIM_W'(sic_pkg::TRIM_LIMIT)
    && roll_trim_r <= sic_pkg::TRIM_W'(sic_pkg::TRIM_LIMIT)
    && roll_trim_r >= -sic_pkg::TRIM_W'(sic_pkg::TRIM_LIMIT))
    else $error("trim outside saturation limits");

  a_cal_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cal_start |=> pitch_trim_r == '0 && roll_trim_r == '0 && cal_r == CAL_LOAD)
    else $error("calibration start did not clear trims");

  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r & ~$past(flags_r)) == '0 || $past(fire))
    else $error("request flag changed without a beat");

endmodule

`default_nettype wire

FILE: rtl/core/sic_merge.sv
// ----------------------------------------------------------------------------
// sic_merge
// Collects the lane values and status into the registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_merge (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                load,
  input  wire logic                                out_ready,
  input  wire logic [sic_pkg::VAL_W-1:0]           values [sic_pkg::NUM_LANES],
  input  wire sic_pkg::status_t                    status,
  output logic                                     out_valid,
  output logic [sic_pkg::VAL_W-1:0]                yaw,
  output logic [sic_pkg::VAL_W-1:0]                throttle,
  output logic [sic_pkg::VAL_W-1:0]                pitch,
  output logic [sic_pkg::VAL_W-1:0]                roll,
  output sic_pkg::status_t                         status_out
);

  logic valid_r, valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      yaw        <= values[sic_pkg::LANE_YAW];
      throttle   <= values[sic_pkg::LANE_THROTTLE];
      pitch      <= values[sic_pkg::LANE_PITCH];
      roll       <= values[sic_pkg::LANE_ROLL];
      status_out <= status;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/stick_input_conditioner_unit.sv
// ----------------------------------------------------------------------------
// stick_input_conditioner_unit
// Four-lane stick conditioner with key driven flags, trims and calibration.
// ----------------------------------------------------------------------------
// in_ch carries one beat per sample set: four raw converter samples and the
// key code. out_ch returns one beat per input beat, in order: four values
// in 0..1000 and the stop, hold height, unlock and calibrating flags.
// cfg_ch writes trim_step (index 0) and stick_center (index 1); it is always
// ready. The user must write it only while no beat is in flight; the block
// itself does not enforce this. A result passes through the scaling register
// of each lane and then the output register, which loads it together with
// the key and calibration update.
// Throughput: one beat per cycle while the receiver takes each result, set
// by the key and calibration state update shared by the lanes.
// When the receiver stalls, the output register holds its beat and the
// scaling stage still takes one more beat; in_ch.ready falls once both are
// full. Reset clears flags, trims, offsets, sums, the calibration counter
// and the previous key, and loads trim_step 10 and stick_center 500.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_input_conditioner_unit #(
  parameter int SAMPLE_BITS = sic_pkg::SAMPLE_BITS_DEF,
  parameter int CAL_SAMPLES = sic_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sic_in_if.sink     in_ch,
  sic_out_if.source  out_ch,
  sic_cfg_if.sink    cfg_ch
);

  logic [sic_pkg::STEP_W-1:0]          trim_step_r, trim_step_nxt;
  logic [sic_pkg::CENTER_W-1:0]        center_r, center_nxt;
  logic                                valid_a_r, valid_a_nxt;
  logic [sic_pkg::KEY_W-1:0]           key_a_r;
  logic                                load_a;
  logic                                fire;
  logic                                out_valid;
  sic_pkg::lane_ctl_t                  ctl;
  sic_pkg::status_t                    status;
  sic_pkg::status_t                    status_q;
  logic signed [sic_pkg::TRIM_W-1:0]   pitch_trim, roll_trim;
  logic [sic_pkg::RAW_W-1:0]           raw    [sic_pkg::NUM_LANES];
  logic signed [sic_pkg::TRIM_W-1:0]   trims  [sic_pkg::NUM_LANES];
  logic [sic_pkg::CENTER_W-1:0]        ctrs   [sic_pkg::NUM_LANES];
  logic [sic_pkg::VAL_W-1:0]           values [sic_pkg::NUM_LANES];

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    trim_step_nxt = trim_step_r;
    center_nxt    = center_r;
    if (cfg_ch.valid) begin
      case (sic_pkg::cfg_idx_t'(cfg_ch.addr))
        sic_pkg::CFG_TRIM_STEP:    trim_step_nxt = cfg_ch.data[sic_pkg::STEP_W-1:0];
        sic_pkg::CFG_STICK_CENTER: center_nxt    = cfg_ch.data[sic_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_step_r <= sic_pkg::TRIM_STEP_RST;
      center_r    <= sic_pkg::STICK_CENTER_RST;
    end else begin
      trim_step_r <= trim_step_nxt;
      center_r    <= center_nxt;
    end
  end

  // two-stage flow: scaling stage, then state update into the output beat
  assign fire        = valid_a_r && (!out_valid || out_ch.ready);
  assign in_ch.ready = !valid_a_r || fire;
  assign load_a      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_a_nxt = valid_a_r;
    if (load_a) begin
      valid_a_nxt = 1'b1;
    end else if (fire) begin
      valid_a_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= valid_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      key_a_r <= in_ch.key_code;
    end
  end

  sic_ctrl #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .key        (key_a_r),
    .trim_step  (trim_step_r),
    .ctl        (ctl),
    .pitch_trim (pitch_trim),
    .roll_trim  (roll_trim),
    .status     (status)
  );

  // lane inputs; throttle calibrates against zero and has no trim
  assign raw[sic_pkg::LANE_YAW]        = in_ch.raw_yaw;
  assign raw[sic_pkg::LANE_THROTTLE]   = in_ch.raw_throttle;
  assign raw[sic_pkg::LANE_PITCH]      = in_ch.raw_pitch;
  assign raw[sic_pkg::LANE_ROLL]       = in_ch.raw_roll;
  assign trims[sic_pkg::LANE_YAW]      = '0;
  assign trims[sic_pkg::LANE_THROTTLE] = '0;
  assign trims[sic_pkg::LANE_PITCH]    = pitch_trim;
  assign trims[sic_pkg::LANE_ROLL]     = roll_trim;
  assign ctrs[sic_pkg::LANE_YAW]       = center_r;
  assign ctrs[sic_pkg::LANE_THROTTLE]  = '0;
  assign ctrs[sic_pkg::LANE_PITCH]     = center_r;
  assign ctrs[sic_pkg::LANE_ROLL]      = center_r;

  for (genvar g = 0; g < sic_pkg::NUM_LANES; g++) begin : g_lane
    sic_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CAL_SAMPLES (CAL_SAMPLES)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (load_a),
      .fire   (fire),
      .raw    (raw[g]),
      .ctl    (ctl),
      .trim   (trims[g]),
      .center (ctrs[g]),
      .value  (values[g])
    );
  end

  sic_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .out_ready  (out_ch.ready),
    .values     (values),
    .status     (status),
    .out_valid  (out_valid),
    .yaw        (out_ch.yaw_out),
    .throttle   (out_ch.throttle_out),
    .pitch      (out_ch.pitch_out),
    .roll       (out_ch.roll_out),
    .status_out (status_q)
  );

  assign out_ch.valid            = out_valid;
  assign out_ch.stop_flag        = status_q.stop;
  assign out_ch.hold_height_flag = status_q.hold;
  assign out_ch.unlock_flag      = status_q.unlock;
  assign out_ch.calibrating      = status_q.calibrating;

endmodule

`default_nettype wire
